/* src/assert_macros.svh */
// Assertion macros for the 4x4 matrix-vector transform block.
// Expects clk_i and rst_ni in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition in the next cycle follows from a condition now.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mvt_pkg.sv */
// Shared widths, types and constants of the matrix-vector transform block.
// No dependencies; used by every module of the block.
package mvt_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int NUM_C  = 4;
  localparam int COL_W  = 2;
  localparam int PROD_W = 2 * DATA_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int ACC_W  = PROD_W + 2;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [PAIR_W-1:0] pair_t;
  typedef logic [ACC_W-1:0]  acc_t;
  typedef logic [COL_W-1:0]  col_t;

  // Packed so that element 0 sits in the lowest bits.
  typedef data_t [NUM_C-1:0]              vec_t;
  typedef prod_t [NUM_C-1:0][NUM_C-1:0]   prod_mat_t;  // [row][col]
  typedef pair_t [NUM_C-1:0][1:0]         pair_mat_t;  // [row][half]
  typedef acc_t  [NUM_C-1:0]              acc_vec_t;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_XFORM = 1'b1
  } mode_e;

  localparam data_t SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

/* src/matrix_vector_transform_4x4_unit.sv */
// 4x4 matrix times vector transform, signed Q16.16, five register stages.
// Depends on mvt_pkg, mvt_mul, mvt_acc, mvt_sat and assert_macros.svh.
//
// Usage:
//   Slave channel s_axis: tuser[0] is the mode, tuser[2:1] the column.
//   A load beat (mode 0) writes tdata as column <column> of the matrix,
//   rows 0..3 from the lowest 32 bits up; it produces no result beat.
//   A transform beat (mode 1) carries a vector and produces one result
//   beat on m_axis with r[row] = sum over col of M[col][row] * v[col],
//   shifted right by 16 (toward minus infinity) and clipped to 32 bits;
//   m_axis_tuser[0] flags that at least one component was clipped.
//   Path: a transform beat passes the input, multiply, pair add, row add
//   and saturate/out registers in turn before it is presented on m_axis.
//   Throughput: one beat per cycle unless m_axis stalls, loads and
//   transforms mixed freely; the sixteen 32x32 multipliers are
//   fully pipelined. Loads take effect in stream order: transforms
//   ahead of a load use the old matrix, those behind it the new one.
//   Stall: each stage holds its beat while the next one is full and
//   blocked, so a stalled receiver backs up the pipe stage by stage;
//   empty stages still take new beats. Nothing is dropped or repeated.
//   Reset: clears every valid bit and loads the all-zero matrix.
`include "assert_macros.svh"

module matrix_vector_transform_4x4_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // comp_0, comp_1, comp_2, comp_3
  input  logic [2:0]   s_axis_tuser,   // mode, column[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // res_0, res_1, res_2, res_3
  output logic [0:0]   m_axis_tuser    // saturated
);

  // Input register stage
  logic           in_vld_q;
  mvt_pkg::mode_e in_mode_q;
  mvt_pkg::col_t  in_col_q;
  mvt_pkg::vec_t  in_vec_q;
  logic           in_adv;

  // Stage links
  logic               mul_vld_i, mul_rdy, mul_vld_o, acc_rdy, acc_vld_o, sat_rdy;
  logic               ld_wr;
  mvt_pkg::prod_mat_t prod;
  mvt_pkg::acc_vec_t  acc;
  mvt_pkg::vec_t      res;
  logic               sat;

  // A load leaves the input stage without needing room downstream.
  assign ld_wr     = in_vld_q && (in_mode_q == mvt_pkg::MODE_LOAD);
  assign mul_vld_i = in_vld_q && (in_mode_q == mvt_pkg::MODE_XFORM);
  assign in_adv    = ld_wr || (mul_vld_i && mul_rdy);
  assign s_axis_tready = !in_vld_q || in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // Capture the beat; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode_q <= mvt_pkg::mode_e'(s_axis_tuser[0]);
      in_col_q  <= s_axis_tuser[2:1];
      in_vec_q  <= s_axis_tdata;
    end
  end

  mvt_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (ld_wr),
    .wr_col_i (in_col_q),
    .vld_i    (mul_vld_i),
    .rdy_o    (mul_rdy),
    .vec_i    (in_vec_q),
    .vld_o    (mul_vld_o),
    .rdy_i    (acc_rdy),
    .prod_o   (prod)
  );

  mvt_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (mul_vld_o),
    .rdy_o  (acc_rdy),
    .prod_i (prod),
    .vld_o  (acc_vld_o),
    .rdy_i  (sat_rdy),
    .acc_o  (acc)
  );

  mvt_sat u_sat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (acc_vld_o),
    .rdy_o  (sat_rdy),
    .acc_i  (acc),
    .vld_o  (m_axis_tvalid),
    .rdy_i  (m_axis_tready),
    .res_o  (res),
    .sat_o  (sat)
  );

  assign m_axis_tdata    = res;
  assign m_axis_tuser[0] = sat;

  // A flagged result must carry at least one clipped component.
  `ASSERT_CHK(a_sat_flag_clip,
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (res[0] == mvt_pkg::SAT_MAX || res[0] == mvt_pkg::SAT_MIN ||
       res[1] == mvt_pkg::SAT_MAX || res[1] == mvt_pkg::SAT_MIN ||
       res[2] == mvt_pkg::SAT_MAX || res[2] == mvt_pkg::SAT_MIN ||
       res[3] == mvt_pkg::SAT_MAX || res[3] == mvt_pkg::SAT_MIN),
    "saturated flag set without a clipped component")

  // Back-pressure on the slave side only comes from a full input stage.
  `ASSERT_CHK(a_stall_needs_beat, !s_axis_tready |-> (in_vld_q && !ld_wr),
    "input stalled while empty or holding a load")

  // A transform handed to the multiplier stage is held there next cycle.
  `ASSERT_NEXT(a_xform_enters, (mul_vld_i && mul_rdy), mul_vld_o,
    "transform beat lost entering the multiplier stage")

endmodule

/* src/mvt_mul.sv */
// Matrix register file and the sixteen product multipliers (one pipeline stage).
// Depends on mvt_pkg.
module mvt_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  mvt_pkg::col_t         wr_col_i,
  input  logic                  vld_i,
  output logic                  rdy_o,
  input  mvt_pkg::vec_t         vec_i,
  output logic                  vld_o,
  input  logic                  rdy_i,
  output mvt_pkg::prod_mat_t    prod_o
);

  mvt_pkg::data_t     mat_q [mvt_pkg::NUM_C][mvt_pkg::NUM_C];  // [col][row]
  mvt_pkg::prod_mat_t prod_d, prod_q;
  logic               vld_q;

  assign rdy_o  = !vld_q || rdy_i;
  assign vld_o  = vld_q;
  assign prod_o = prod_q;

  always_comb begin
    for (int r = 0; r < mvt_pkg::NUM_C; r++) begin
      for (int c = 0; c < mvt_pkg::NUM_C; c++) begin
        prod_d[r][c] = $signed(mat_q[c][r]) * $signed(vec_i[c]);
      end
    end
  end

  // Matrix column write; reset gives the zero matrix.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < mvt_pkg::NUM_C; c++) begin
        for (int r = 0; r < mvt_pkg::NUM_C; r++) begin
          mat_q[c][r] <= '0;
        end
      end
    end else if (wr_en_i) begin
      for (int r = 0; r < mvt_pkg::NUM_C; r++) begin
        mat_q[wr_col_i][r] <= vec_i[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      prod_q <= prod_d;
    end
  end

endmodule

/* src/mvt_acc.sv */
// Two-stage adder tree: pair sums per row, then the full row sum.
// Depends on mvt_pkg.
module mvt_acc (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  output logic                  rdy_o,
  input  mvt_pkg::prod_mat_t    prod_i,
  output logic                  vld_o,
  input  logic                  rdy_i,
  output mvt_pkg::acc_vec_t     acc_o
);

  mvt_pkg::pair_mat_t pair_d, pair_q;
  mvt_pkg::acc_vec_t  acc_d, acc_q;
  logic               vld_a_q, vld_b_q;
  logic               rdy_b;

  assign rdy_b = !vld_b_q || rdy_i;
  assign rdy_o = !vld_a_q || rdy_b;
  assign vld_o = vld_b_q;
  assign acc_o = acc_q;

  always_comb begin
    for (int r = 0; r < mvt_pkg::NUM_C; r++) begin
      for (int h = 0; h < 2; h++) begin
        pair_d[r][h] = mvt_pkg::PAIR_W'($signed(prod_i[r][2*h]))
                     + mvt_pkg::PAIR_W'($signed(prod_i[r][2*h+1]));
      end
      acc_d[r] = mvt_pkg::ACC_W'($signed(pair_q[r][0]))
               + mvt_pkg::ACC_W'($signed(pair_q[r][1]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (rdy_o) begin
        vld_a_q <= vld_i;
      end
      if (rdy_b) begin
        vld_b_q <= vld_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      pair_q <= pair_d;
    end
    if (rdy_b && vld_a_q) begin
      acc_q <= acc_d;
    end
  end

endmodule

/* src/mvt_sat.sv */
// Fraction shift, saturation and the output register of the block.
// Depends on mvt_pkg.
module mvt_sat (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  output logic               rdy_o,
  input  mvt_pkg::acc_vec_t  acc_i,
  output logic               vld_o,
  input  logic               rdy_i,
  output mvt_pkg::vec_t      res_o,
  output logic               sat_o
);

  logic signed [mvt_pkg::ACC_W-1:0] shifted [mvt_pkg::NUM_C];
  logic [mvt_pkg::ACC_W-mvt_pkg::DATA_W:0] top [mvt_pkg::NUM_C];
  logic [mvt_pkg::NUM_C-1:0] clip;
  mvt_pkg::vec_t res_d, res_q;
  logic          sat_q, vld_q;

  assign rdy_o = !vld_q || rdy_i;
  assign vld_o = vld_q;
  assign res_o = res_q;
  assign sat_o = sat_q;

  always_comb begin
    for (int r = 0; r < mvt_pkg::NUM_C; r++) begin
      shifted[r] = $signed(acc_i[r]) >>> mvt_pkg::FRAC_W;
      top[r]     = shifted[r][mvt_pkg::ACC_W-1:mvt_pkg::DATA_W-1];
      // In range only when all bits above the result sign agree with it.
      clip[r]    = !((&top[r]) || !(|top[r]));
      if (!clip[r]) begin
        res_d[r] = shifted[r][mvt_pkg::DATA_W-1:0];
      end else if (acc_i[r][mvt_pkg::ACC_W-1]) begin
        res_d[r] = mvt_pkg::SAT_MIN;
      end else begin
        res_d[r] = mvt_pkg::SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      res_q <= res_d;
      sat_q <= |clip;
    end
  end

endmodule
